// ===== hdl/sif_pkg.sv =====
`timescale 1ns / 1ps

package sif_pkg;

  localparam int TAPS_DEF   = 60;
  localparam int IDX_W      = 6;
  localparam int COEF_W     = 18;
  localparam int SAMP_W     = 16;
  localparam int PROD_W     = COEF_W + SAMP_W;
  localparam int ACC_W      = 40;
  localparam int FRAC_W     = 15;
  localparam int RND_W      = ACC_W - FRAC_W;
  localparam int DIFF_W     = RND_W + 1;
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctl_t;

endpackage

// ===== hdl/sif_if.sv =====
`timescale 1ns / 1ps

interface sif_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   req_type;
  logic        [sif_pkg::IDX_W-1:0]       tap_index;
  logic signed [sif_pkg::COEF_W-1:0]      tap_value;
  logic signed [sif_pkg::SAMP_W-1:0]      tx_sample;
  logic signed [sif_pkg::SAMP_W-1:0]      rx_sample;

  modport source (output valid, req_type, tap_index, tap_value, tx_sample, rx_sample,
                  input ready);
  modport sink (input valid, req_type, tap_index, tap_value, tx_sample, rx_sample,
                output ready);
endinterface

interface sif_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [sif_pkg::SAMP_W-1:0] clean_sample;
  logic                              saturated;

  modport source (output valid, clean_sample, saturated, input ready);
  modport sink (input valid, clean_sample, saturated, output ready);
endinterface

// ===== hdl/sif_ram.sv =====
`timescale 1ns / 1ps

module sif_ram #(
  parameter int DEPTH = sif_pkg::TAPS_DEF,
  parameter int WIDTH = sif_pkg::COEF_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/sif_mac.sv =====
`timescale 1ns / 1ps

module sif_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sif_pkg::mac_ctl_t                  ctl,
  input  logic signed [sif_pkg::COEF_W-1:0]  coef,
  input  logic signed [sif_pkg::SAMP_W-1:0]  samp,
  output logic signed [sif_pkg::ACC_W-1:0]   acc,
  output logic                               pend
);

  logic signed [sif_pkg::PROD_W-1:0] prod_r;
  logic                              prod_v_r;
  logic signed [sif_pkg::ACC_W-1:0]  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= coef * samp;
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + sif_pkg::ACC_W'(prod_r);
    end
  end

  assign acc  = acc_r;
  assign pend = prod_v_r;

endmodule

// ===== hdl/self_interference_fir_canceller.sv =====
// a load beat is written in ST_IDLE, which stays ready; a sample beat passes ST_RUN,
// ST_DRAIN (rounding) and ST_SAT (saturation, waits on an unread result), then ST_IDLE
// takes the next beat; the rate is set by the single shared 18x16 MAC, one tap per cycle
// reset (rst_n low, synchronous) clears the tap and history valid bits, so both
// stores read as zero until written; no clearing pass is needed
`timescale 1ns / 1ps

module self_interference_fir_canceller #(
  parameter int TAPS = sif_pkg::TAPS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sif_req_if.sink    in_req,
  sif_res_if.source  out_res
);

  localparam int AW = $clog2(TAPS);
  localparam int CW = $clog2(TAPS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_SAT} state_t;

  state_t                              state_r, state_nxt;
  logic [CW-1:0]                       j_r, j_nxt;
  logic [AW-1:0]                       oldest_r, oldest_nxt;
  logic [AW-1:0]                       haddr_r, haddr_nxt;
  logic [TAPS-1:0]                     tap_vld_r, tap_vld_nxt;
  logic [TAPS-1:0]                     hist_vld_r, hist_vld_nxt;
  logic                                rd_v_r, rd_v_nxt;
  logic                                rd_tv_r, rd_tv_nxt;
  logic                                rd_hv_r, rd_hv_nxt;
  logic signed [sif_pkg::SAMP_W-1:0]   rx_r, rx_nxt;
  logic signed [sif_pkg::RND_W-1:0]    rnd_r, rnd_nxt;
  logic                                ov_r, ov_nxt;
  logic signed [sif_pkg::SAMP_W-1:0]   clean_r, clean_nxt;
  logic                                sat_r, sat_nxt;

  logic                                accept;
  logic                                rd_en;
  logic                                tap_we;
  logic                                hist_we;
  logic                                idx_ok;
  logic [sif_pkg::COEF_W-1:0]          tap_q;
  logic [sif_pkg::SAMP_W-1:0]          hist_q;
  sif_pkg::mac_ctl_t                   mac_ctl;
  logic signed [sif_pkg::COEF_W-1:0]   mac_coef;
  logic signed [sif_pkg::SAMP_W-1:0]   mac_samp;
  logic signed [sif_pkg::ACC_W-1:0]    acc;
  logic                                mac_pend;
  logic signed [sif_pkg::ACC_W-1:0]    acc_rnd;
  logic signed [sif_pkg::DIFF_W-1:0]   diff;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
    logic [AW-1:0] r;
    if (a == AW'(TAPS - 1)) begin
      r = '0;
    end else begin
      r = a + AW'(1);
    end
    return r;
  endfunction

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign idx_ok       = ({1'b0, in_req.tap_index} < (sif_pkg::IDX_W + 1)'(TAPS));
  assign tap_we       = accept && (in_req.req_type == sif_pkg::REQ_LOAD) && idx_ok;
  assign hist_we      = accept && (in_req.req_type == sif_pkg::REQ_SAMPLE);
  assign rd_en        = (state_r == ST_RUN);

  sif_ram #(.DEPTH(TAPS), .WIDTH(sif_pkg::COEF_W)) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (in_req.tap_index[AW-1:0]),
    .wdata (in_req.tap_value),
    .re    (rd_en),
    .raddr (j_r[AW-1:0]),
    .rdata (tap_q)
  );

  sif_ram #(.DEPTH(TAPS), .WIDTH(sif_pkg::SAMP_W)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (oldest_r),
    .wdata (in_req.tx_sample),
    .re    (rd_en),
    .raddr (haddr_r),
    .rdata (hist_q)
  );

  assign mac_ctl.clr = hist_we;
  assign mac_ctl.en  = rd_v_r;
  assign mac_coef    = rd_tv_r ? signed'(tap_q) : '0;
  assign mac_samp    = rd_hv_r ? signed'(hist_q) : '0;

  sif_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .coef  (mac_coef),
    .samp  (mac_samp),
    .acc   (acc),
    .pend  (mac_pend)
  );

  assign acc_rnd = acc + sif_pkg::ACC_W'(sif_pkg::ROUND_HALF);
  assign diff    = sif_pkg::DIFF_W'(rx_r) - sif_pkg::DIFF_W'(rnd_r);

  always_comb begin
    state_nxt    = state_r;
    j_nxt        = j_r;
    oldest_nxt   = oldest_r;
    haddr_nxt    = haddr_r;
    tap_vld_nxt  = tap_vld_r;
    hist_vld_nxt = hist_vld_r;
    rd_v_nxt     = rd_en;
    rd_tv_nxt    = tap_vld_r[j_r[AW-1:0]];
    rd_hv_nxt    = hist_vld_r[haddr_r];
    rx_nxt       = rx_r;
    rnd_nxt      = rnd_r;
    ov_nxt       = ov_r && !out_res.ready;
    clean_nxt    = clean_r;
    sat_nxt      = sat_r;
    unique case (state_r)
      ST_IDLE: begin
        if (tap_we) begin
          tap_vld_nxt[in_req.tap_index[AW-1:0]] = 1'b1;
        end
        if (hist_we) begin
          hist_vld_nxt[oldest_r] = 1'b1;
          oldest_nxt             = wrap_inc(oldest_r);
          haddr_nxt              = wrap_inc(oldest_r);
          j_nxt                  = '0;
          rx_nxt                 = in_req.rx_sample;
          state_nxt              = ST_RUN;
        end
      end
      ST_RUN: begin
        j_nxt     = j_r + CW'(1);
        haddr_nxt = wrap_inc(haddr_r);
        if (j_r == CW'(TAPS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !mac_pend) begin
          rnd_nxt   = acc_rnd[sif_pkg::ACC_W-1:sif_pkg::FRAC_W];
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        if (!ov_r || out_res.ready) begin
          ov_nxt = 1'b1;
          if (diff[sif_pkg::DIFF_W-1:sif_pkg::SAMP_W-1] == '0 ||
              diff[sif_pkg::DIFF_W-1:sif_pkg::SAMP_W-1] == '1) begin
            clean_nxt = diff[sif_pkg::SAMP_W-1:0];
            sat_nxt   = 1'b0;
          end else begin
            clean_nxt = diff[sif_pkg::DIFF_W-1] ? {1'b1, {(sif_pkg::SAMP_W-1){1'b0}}}
                                                : {1'b0, {(sif_pkg::SAMP_W-1){1'b1}}};
            sat_nxt   = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      j_r        <= '0;
      oldest_r   <= '0;
      haddr_r    <= '0;
      tap_vld_r  <= '0;
      hist_vld_r <= '0;
      rd_v_r     <= 1'b0;
      rd_tv_r    <= 1'b0;
      rd_hv_r    <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      j_r        <= j_nxt;
      oldest_r   <= oldest_nxt;
      haddr_r    <= haddr_nxt;
      tap_vld_r  <= tap_vld_nxt;
      hist_vld_r <= hist_vld_nxt;
      rd_v_r     <= rd_v_nxt;
      rd_tv_r    <= rd_tv_nxt;
      rd_hv_r    <= rd_hv_nxt;
      ov_r       <= ov_nxt;
      rx_r       <= rx_nxt;
      rnd_r      <= rnd_nxt;
      clean_r    <= clean_nxt;
      sat_r      <= sat_nxt;
    end
  end

  assign out_res.valid        = ov_r;
  assign out_res.clean_sample = clean_r;
  assign out_res.saturated    = sat_r;

  // every run cycle issues one tap read
  a_run_issues: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |=> rd_v_r)
    else $error("run cycle without tap read");

  // a new result only comes out of the saturation step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r == ST_SAT))
    else $error("result beat raised outside saturation step");

  // a load beat leaves the delay line alone
  a_load_hist: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.req_type == sif_pkg::REQ_LOAD) |=> $stable(hist_vld_r) &&
      $stable(oldest_r))
    else $error("load beat touched delay line");

  // no accumulation in flight while taking a beat
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> (!rd_v_r && !mac_pend))
    else $error("ready while accumulation pending");

endmodule
